### src/iom_pkg.sv
// shared types and constants for the insertion ordered map
package iom_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int SLOT_W   = $clog2(ENTRIES);
  localparam int LINK_W   = SLOT_W + 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(ENTRIES);

  localparam int IN_W      = 2 + KEY_W + VAL_W;
  localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADKEY  = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // last member sits in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic [KEY_W-1:0] tail_key;
    logic [KEY_W-1:0] head_key;
    logic             created;
    logic [VAL_W-1:0] result_value;
    status_t          status;
  } result_t;

  localparam int OUT_W = $bits(result_t);

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOOKUP,
    CS_EXEC,
    CS_RESP
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic execute;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic mutate;
  } dp_stat_t;

endpackage

### src/iom_ctrl.sv
// request sequencer: capture, match, update, hold result
module iom_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output iom_pkg::dp_cmd_t  cmd,
  input  iom_pkg::dp_stat_t stat
);

  iom_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iom_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    cmd           = '0;
    unique case (state)
      iom_pkg::CS_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = iom_pkg::CS_LOOKUP;
        end
      end
      iom_pkg::CS_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = iom_pkg::CS_EXEC;
      end
      iom_pkg::CS_EXEC: begin
        cmd.execute = 1'b1;
        // tables change only on a new add or a remove that hits
        cmd.commit  = stat.mutate;
        state_next  = iom_pkg::CS_RESP;
      end
      iom_pkg::CS_RESP: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_next = iom_pkg::CS_IDLE;
        end
      end
      default: begin
        state_next = iom_pkg::CS_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request accepted while a result is pending");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> ##3 m_axis_tvalid)
    else $error("result not presented three cycles after accept");
`endif

endmodule

### src/iom_datapath.sv
// slot tables, insertion list, parallel key match and result register
module iom_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [iom_pkg::IN_DATA_W-1:0] in_data,
  input  iom_pkg::dp_cmd_t              cmd,
  output iom_pkg::dp_stat_t             stat,
  output iom_pkg::result_t              result
);

  localparam int SW = iom_pkg::SLOT_W;
  localparam int LW = iom_pkg::LINK_W;
  localparam int CW = iom_pkg::CNT_W;
  localparam int KW = iom_pkg::KEY_W;
  localparam int VW = iom_pkg::VAL_W;
  localparam int N  = iom_pkg::ENTRIES;

  // captured request
  iom_pkg::op_t   op_r;
  logic [KW-1:0]  key_r;
  logic [VW-1:0]  val_r;

  // slot tables
  logic [N-1:0]   valid;
  logic [KW-1:0]  key_tab  [N];
  logic [VW-1:0]  val_tab  [N];
  logic [LW-1:0]  prev_tab [N];
  logic [LW-1:0]  next_tab [N];

  // list ends
  logic [LW-1:0]  head, head_next;
  logic [LW-1:0]  tail, tail_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [KW-1:0]  head_key, head_key_next;
  logic [KW-1:0]  tail_key, tail_key_next;

  // match results
  logic           hit_c, free_ok_c, bad_c, mutate_c;
  logic [SW-1:0]  hit_idx_c, free_idx_c;
  logic           hit_r, free_ok_r, bad_r, mutate_r;
  logic [SW-1:0]  hit_idx_r, free_idx_r;

  // remove neighbors
  logic [LW-1:0]  rm_prev, rm_next, fix_link;
  logic           prev_none, next_none;
  logic [KW-1:0]  fix_key;

  iom_pkg::result_t res_c;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= iom_pkg::op_t'(in_data[1:0]);
      key_r <= in_data[KW+1:2];
      val_r <= in_data[KW+VW+1:KW+2];
    end
  end

  // parallel match, lowest slot wins
  always_comb begin
    hit_c      = 1'b0;
    free_ok_c  = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (valid[i] && key_tab[i] == key_r) begin
        hit_c     = 1'b1;
        hit_idx_c = SW'(i);
      end
      if (!valid[i]) begin
        free_ok_c  = 1'b1;
        free_idx_c = SW'(i);
      end
    end
    bad_c    = (key_r == '0) || (op_r == iom_pkg::OP_RSVD);
    mutate_c = !bad_c && (((op_r == iom_pkg::OP_ADD) && !hit_c && free_ok_c) ||
                          ((op_r == iom_pkg::OP_REMOVE) && hit_c));
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r      <= hit_c;
      free_ok_r  <= free_ok_c;
      hit_idx_r  <= hit_idx_c;
      free_idx_r <= free_idx_c;
      bad_r      <= bad_c;
      mutate_r   <= mutate_c;
    end
  end

  assign stat.mutate = mutate_r;

  assign rm_prev   = prev_tab[hit_idx_r];
  assign rm_next   = next_tab[hit_idx_r];
  assign prev_none = (rm_prev == iom_pkg::NONE_LINK);
  assign next_none = (rm_next == iom_pkg::NONE_LINK);
  // the one neighbor whose key may become a new end key
  assign fix_link  = prev_none ? rm_next : rm_prev;
  assign fix_key   = key_tab[fix_link[SW-1:0]];

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    cnt_next      = cnt;
    head_key_next = head_key;
    tail_key_next = tail_key;
    if (cmd.commit) begin
      if (op_r == iom_pkg::OP_ADD) begin
        if (tail == iom_pkg::NONE_LINK) begin
          head_next     = {1'b0, free_idx_r};
          head_key_next = key_r;
        end
        tail_next     = {1'b0, free_idx_r};
        tail_key_next = key_r;
        cnt_next      = cnt + CW'(1);
      end else begin
        if (prev_none) begin
          head_next     = rm_next;
          head_key_next = next_none ? '0 : fix_key;
        end
        if (next_none) begin
          tail_next     = rm_prev;
          tail_key_next = prev_none ? '0 : fix_key;
        end
        cnt_next = cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      head     <= iom_pkg::NONE_LINK;
      tail     <= iom_pkg::NONE_LINK;
      cnt      <= '0;
      head_key <= '0;
      tail_key <= '0;
    end else begin
      head     <= head_next;
      tail     <= tail_next;
      cnt      <= cnt_next;
      head_key <= head_key_next;
      tail_key <= tail_key_next;
      if (cmd.commit) begin
        if (op_r == iom_pkg::OP_ADD) begin
          valid[free_idx_r] <= 1'b1;
        end else begin
          valid[hit_idx_r] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_r == iom_pkg::OP_ADD) begin
        key_tab[free_idx_r]  <= key_r;
        val_tab[free_idx_r]  <= val_r;
        prev_tab[free_idx_r] <= tail;
        next_tab[free_idx_r] <= iom_pkg::NONE_LINK;
        if (tail != iom_pkg::NONE_LINK) begin
          next_tab[tail[SW-1:0]] <= {1'b0, free_idx_r};
        end
      end else begin
        if (!prev_none) begin
          next_tab[rm_prev[SW-1:0]] <= rm_next;
        end
        if (!next_none) begin
          prev_tab[rm_next[SW-1:0]] <= rm_prev;
        end
      end
    end
  end

  always_comb begin
    res_c              = '0;
    res_c.status       = iom_pkg::ST_OK;
    res_c.head_key     = head_key_next;
    res_c.tail_key     = tail_key_next;
    res_c.entry_count  = cnt_next;
    if (bad_r) begin
      res_c.status = iom_pkg::ST_BADKEY;
    end else if (hit_r) begin
      // existing entry: add, find and remove all report the stored value
      res_c.result_value = val_tab[hit_idx_r];
    end else if (op_r == iom_pkg::OP_ADD) begin
      if (free_ok_r) begin
        res_c.result_value = val_r;
        res_c.created      = 1'b1;
      end else begin
        res_c.status = iom_pkg::ST_FULL;
      end
    end else begin
      res_c.status = iom_pkg::ST_MISSING;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      result <= res_c;
    end
  end

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    cnt == CW'($countones(valid)))
    else $error("entry count differs from occupied slots");

  a_empty_list: assert property (@(posedge clk) disable iff (rst)
    (head == iom_pkg::NONE_LINK) == (cnt == '0) &&
    (tail == iom_pkg::NONE_LINK) == (cnt == '0))
    else $error("list ends disagree with entry count");
`endif

endmodule

### src/insertion_ordered_map.sv
// insertion ordered map: one request in flight at a time
// each accepted beat passes through capture, a parallel key match over all
// slots, and the table and list update with the result registered
// a new request is accepted only after the previous result has been taken
// reset: all slots free, list empty, count zero; no clearing pass needed
module insertion_ordered_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // req_type[1:0], key[33:2], value[65:34], zero fill above
  input  logic [iom_pkg::IN_DATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[1:0], result_value[33:2], created[34], head_key[66:35],
  // tail_key[98:67], entry_count[103:99]
  output logic [iom_pkg::OUT_W-1:0]     m_axis_tdata
);

  iom_pkg::dp_cmd_t  cmd;
  iom_pkg::dp_stat_t stat;
  iom_pkg::result_t  result;

  iom_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd),
    .stat          (stat)
  );

  iom_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .in_data (s_axis_tdata),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

  assign m_axis_tdata = result;

endmodule
